// ===== hw/rtl/strs_pkg.sv =====
// Shared types and constants for the segment tree range sum block.
package strs_pkg;

    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_WR,
        ST_SET_ADD,
        ST_Q_LEFT,
        ST_Q_RIGHT,
        ST_Q_DONE
    } t_state;

endpackage

// ===== hw/rtl/segment_tree_range_sum.sv =====
// Segment tree over LEAVES signed 32-bit elements: point set and range sum query.

// Keeps 2*LEAVES node sums in one on-chip memory (one write port, one registered
// read port); entry LEAVES+i is element i and entry k is the sum of entries 2k and
// 2k+1. After reset a clearing pass writes zero to every entry, one a cycle, and
// the input stays stalled meanwhile. A set word (op 0) writes the leaf and walks
// up to the root: each level below the root takes a write-plus-sibling-read step
// and then an add step, and the root takes one write step, after which the next
// word can be taken; a position at or beyond LEAVES is dropped at once.
// A query word (op 1) clips range_high to LEAVES-1 and walks the half-open leaf
// span toward the root, with a left-end step and a right-end step per level, then
// a closing check and a result step that loads the output register once it is
// free; the next word can be taken after that. An empty range goes straight to
// the result step and returns 0.
// Both walks share one 32-bit adder and the single read port, which set the rate.
// The input is stalled for the whole walk. A query result lands in an output
// register, so the next word is taken while that result waits to be drained.
module segment_tree_range_sum #(
    parameter int LEAVES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic [strs_pkg::IDX_W-1:0]          i_position,
    input  logic signed [strs_pkg::DATA_W-1:0]  i_value,
    input  logic [strs_pkg::IDX_W-1:0]          i_range_low,
    input  logic [strs_pkg::IDX_W-1:0]          i_range_high,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [strs_pkg::DATA_W-1:0]  o_range_sum
);

    localparam int DEPTH = 2 * LEAVES;
    localparam int NW    = $clog2(DEPTH);
    localparam int RW    = NW + 1;
    localparam int XW    = (RW > strs_pkg::IDX_W) ? RW : strs_pkg::IDX_W;

    // node memory and its registered read data
    logic [strs_pkg::DATA_W-1:0] mem [0:DEPTH-1];
    logic [strs_pkg::DATA_W-1:0] r_rd_data;

    strs_pkg::t_state r_state, n_state;

    logic [NW-1:0]               r_clr, n_clr;      // clearing pass address
    logic [NW-1:0]               r_k, n_k;          // set walk node
    logic [RW-1:0]               r_l, n_l;          // query span, half open
    logic [RW-1:0]               r_r, n_r;
    logic [strs_pkg::DATA_W-1:0] r_sum, n_sum;      // running node value or query total
    logic                        r_pend, n_pend;    // read data waits to be added
    logic                        r_out_valid, n_out_valid;
    logic [strs_pkg::DATA_W-1:0] r_out_data, n_out_data;

    logic                        mem_we;
    logic [NW-1:0]               mem_waddr;
    logic [strs_pkg::DATA_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [NW-1:0]               mem_raddr;

    logic                        in_acc;
    logic [XW-1:0]               leaves_x;
    logic [XW-1:0]               pos_x;
    logic [XW-1:0]               lo_x;
    logic [XW-1:0]               rh_x;
    logic [XW-1:0]               hi_x;
    logic                        pos_ok;
    logic                        q_empty;
    logic [NW-1:0]               leaf_idx;
    logic [RW-1:0]               q_l;
    logic [RW-1:0]               q_r;
    logic                        l_lt_r;
    logic [RW-1:0]               r_m1;
    logic                        slot_free;
    logic [strs_pkg::DATA_W-1:0] sum_add;

    assign in_acc    = i_in_valid && !o_in_stall;

    // decode of an incoming word, in a width that holds both the field and 2*LEAVES
    assign leaves_x  = XW'(LEAVES);
    assign pos_x     = XW'(i_position);
    assign lo_x      = XW'(i_range_low);
    assign rh_x      = XW'(i_range_high);
    assign hi_x      = (rh_x >= leaves_x) ? (leaves_x - XW'(1)) : rh_x;
    assign pos_ok    = pos_x < leaves_x;
    assign q_empty   = lo_x > hi_x;
    assign leaf_idx  = NW'(pos_x + leaves_x);
    assign q_l       = RW'(lo_x + leaves_x);
    assign q_r       = RW'(hi_x + leaves_x + XW'(1));

    assign l_lt_r    = r_l < r_r;
    assign r_m1      = r_r - RW'(1);
    assign slot_free = !r_out_valid || !i_out_stall;

    // the one shared adder
    assign sum_add   = r_sum + r_rd_data;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            strs_pkg::ST_CLEAR: begin
                if (r_clr == NW'(DEPTH - 1)) begin
                    n_state = strs_pkg::ST_IDLE;
                end
            end
            strs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_op == strs_pkg::OP_SET) begin
                        n_state = pos_ok ? strs_pkg::ST_SET_WR : strs_pkg::ST_IDLE;
                    end else begin
                        n_state = q_empty ? strs_pkg::ST_Q_DONE : strs_pkg::ST_Q_LEFT;
                    end
                end
            end
            strs_pkg::ST_SET_WR: begin
                n_state = (r_k == NW'(1)) ? strs_pkg::ST_IDLE : strs_pkg::ST_SET_ADD;
            end
            strs_pkg::ST_SET_ADD: begin
                n_state = strs_pkg::ST_SET_WR;
            end
            strs_pkg::ST_Q_LEFT: begin
                n_state = l_lt_r ? strs_pkg::ST_Q_RIGHT : strs_pkg::ST_Q_DONE;
            end
            strs_pkg::ST_Q_RIGHT: begin
                n_state = strs_pkg::ST_Q_LEFT;
            end
            strs_pkg::ST_Q_DONE: begin
                if (slot_free) begin
                    n_state = strs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = strs_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs: input stall and memory port controls
    always_comb begin
        o_in_stall = 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = r_k;
        mem_wdata  = r_sum;
        mem_re     = 1'b0;
        mem_raddr  = r_k ^ NW'(1);
        case (r_state)
            strs_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            strs_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            strs_pkg::ST_SET_WR: begin
                // write this node and fetch its sibling for the parent sum
                mem_we = 1'b1;
                mem_re = (r_k != NW'(1));
            end
            strs_pkg::ST_Q_LEFT: begin
                mem_re    = l_lt_r && r_l[0];
                mem_raddr = r_l[NW-1:0];
            end
            strs_pkg::ST_Q_RIGHT: begin
                mem_re    = r_r[0];
                mem_raddr = r_m1[NW-1:0];
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_clr       = r_clr;
        n_k         = r_k;
        n_l         = r_l;
        n_r         = r_r;
        n_sum       = r_sum;
        n_pend      = mem_re;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        if (r_pend) begin
            n_sum = sum_add;
        end
        case (r_state)
            strs_pkg::ST_CLEAR: begin
                n_clr = r_clr + NW'(1);
            end
            strs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_op == strs_pkg::OP_SET) begin
                        n_k   = leaf_idx;
                        n_sum = i_value;
                    end else begin
                        n_l   = q_l;
                        n_r   = q_r;
                        n_sum = '0;
                    end
                end
            end
            strs_pkg::ST_SET_WR: begin
                n_k = r_k >> 1;
            end
            strs_pkg::ST_Q_LEFT: begin
                if (l_lt_r && r_l[0]) begin
                    n_l = r_l + RW'(1);
                end
            end
            strs_pkg::ST_Q_RIGHT: begin
                // step both ends up one level
                n_l = r_l >> 1;
                n_r = (r_r[0] ? r_m1 : r_r) >> 1;
            end
            strs_pkg::ST_Q_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_sum;
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= strs_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_l        <= n_l;
        r_r        <= n_r;
        r_sum      <= n_sum;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out_data;

`ifndef SYNTHESIS
    // read data is only ever pending right after a reading state
    a_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(r_state) == strs_pkg::ST_SET_WR ||
                    $past(r_state) == strs_pkg::ST_Q_LEFT ||
                    $past(r_state) == strs_pkg::ST_Q_RIGHT))
        else $error("read data pending without a read");

    // the set walk never reaches the unused node zero
    a_k_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == strs_pkg::ST_SET_WR) |-> (r_k != '0))
        else $error("set walk reached node zero");

    // the query span never inverts
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == strs_pkg::ST_Q_LEFT || r_state == strs_pkg::ST_Q_RIGHT)
            |-> (r_l <= r_r))
        else $error("query span inverted");

    // a new result only appears out of the query completion state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> ($past(r_state) == strs_pkg::ST_Q_DONE))
        else $error("result loaded outside query completion");

    // an in-range set word starts the tree walk
    a_set_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_op == strs_pkg::OP_SET && pos_ok) |=> (r_state == strs_pkg::ST_SET_WR))
        else $error("set word did not start the walk");
`endif

endmodule
